### src/sccb_pkg.sv
// Shared types and constants for the SCCB master bit sequencer.
package sccb_pkg;

    localparam int unsigned PHASE_W = 10;
    localparam int unsigned ACK_W   = 12;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PIDX_W  = 5;
    localparam int unsigned KIND_W  = 3;
    localparam int unsigned CFG_W   = 12;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 10'd100;
    localparam logic [ACK_W-1:0]   ACK_WAIT_RST    = 12'd1000;

    // configuration register indexes
    localparam logic CFG_PHASE_TICKS = 1'b0;
    localparam logic CFG_ACK_WAIT    = 1'b1;

    // input item kinds
    typedef enum logic [KIND_W-1:0] {
        K_TICK  = 3'd0,
        K_START = 3'd1,
        K_STOP  = 3'd2,
        K_WRITE = 3'd3,
        K_READ  = 3'd4,
        K_NOACK = 3'd5
    } t_kind;

    // active command sequence
    typedef enum logic [5:0] {
        CS_IDLE  = 6'b000001,
        CS_START = 6'b000010,
        CS_STOP  = 6'b000100,
        CS_WRITE = 6'b001000,
        CS_READ  = 6'b010000,
        CS_NOACK = 6'b100000
    } t_cmd;

    // write phase holding SCL high for the acknowledge
    localparam logic [PIDX_W-1:0] WR_ACK_PHASE = 5'd26;
    localparam logic [PIDX_W-1:0] WR_REL_PHASE = 5'd25;
    localparam logic [PIDX_W-1:0] WR_LOW_PHASE = 5'd27;
    localparam logic [PIDX_W-1:0] WR_BIT_END   = 5'd24;

    typedef struct packed {
        logic              scl;
        logic              sda_out;
        logic              sda_drive;
        logic              busy;
        logic              done;
        logic              ack_ok;
        logic [BYTE_W-1:0] read_value;
        logic              rejected;
    } t_result;

    function automatic logic [PIDX_W-1:0] phase_total(input t_cmd cmd);
        case (cmd)
            CS_START: phase_total = 5'd4;
            CS_STOP:  phase_total = 5'd3;
            CS_NOACK: phase_total = 5'd4;
            CS_WRITE: phase_total = 5'd28;
            CS_READ:  phase_total = 5'd25;
            default:  phase_total = 5'd0;
        endcase
    endfunction

    // p / 3 for p < 32, by reciprocal multiply
    function automatic logic [PIDX_W-1:0] div3(input logic [PIDX_W-1:0] p);
        logic [PIDX_W+4-1:0] prod;
        prod = {4'd0, p} * 9'd11;
        div3 = {1'b0, prod[PIDX_W+4-1:5]};
    endfunction

    function automatic logic [1:0] mod3(input logic [PIDX_W-1:0] p);
        logic [PIDX_W+1:0] q3;
        logic [PIDX_W+1:0] diff;
        q3   = {2'd0, div3(p)} * 7'd3;
        diff = {2'd0, p} - q3;
        mod3 = diff[1:0];
    endfunction

endpackage

### src/sccb_master_bit_sequencer.sv
// SCCB master bit sequencer: command/tick input, pin-control result per beat.
//
// Input channel (i_valid / o_stall): each beat is a tick (carrying the sampled
// SDA level) or a command (start, stop, write byte, read byte, no-ack). A
// command that arrives while a sequence runs is flagged rejected and dropped.
// Output channel (o_valid / i_stall): exactly one result beat per input beat,
// carrying the SCL/SDA controls, busy, done, ack and the last read byte.
// The result is registered in the output stage; one beat is taken per cycle
// while o_stall is low, since the whole state update is a single short step
// on the phase and tick counters. A two-entry output stage (result register
// plus skid register) lets the input keep flowing for one beat while the
// receiver stalls; o_stall rises only once both entries hold results.
// Configuration writes (i_cfg_we) set phase_ticks (index 0) and
// ack_wait_ticks (index 1); they are taken at once and must come while idle.
// Synchronous reset releases both lines (SCL high, SDA driven high), returns
// to idle, restores the register defaults and empties the output stage.
module sccb_master_bit_sequencer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_index,
    input  logic [sccb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [sccb_pkg::KIND_W-1:0]   i_kind,
    input  logic [sccb_pkg::BYTE_W-1:0]   i_data,
    input  logic                          i_sda_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_scl,
    output logic                          o_sda_out,
    output logic                          o_sda_drive,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic                          o_ack_ok,
    output logic [sccb_pkg::BYTE_W-1:0]   o_read_value,
    output logic                          o_rejected
);
    import sccb_pkg::*;

    logic [PHASE_W-1:0] r_phase_ticks;
    logic [ACK_W-1:0]   r_ack_wait;

    logic               r_scl, n_scl;
    logic               r_sda, n_sda;
    logic               r_sda_en, n_sda_en;
    t_cmd               r_cmd, n_cmd;
    logic [PIDX_W-1:0]  r_phase, n_phase;
    logic [ACK_W-1:0]   r_tick, n_tick;
    logic [BYTE_W-1:0]  r_shift, n_shift;
    logic               r_ack, n_ack;
    logic [BYTE_W-1:0]  r_last_read, n_last_read;

    t_result            res;
    t_result            r_out, r_skid;
    logic               r_out_vld, r_skid_vld;
    logic               accept;
    logic               out_free;

    assign o_stall  = r_skid_vld;
    assign accept   = i_valid & ~r_skid_vld;
    assign out_free = ~r_out_vld | ~i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_ticks <= PHASE_TICKS_RST;
            r_ack_wait    <= ACK_WAIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PHASE_TICKS: r_phase_ticks <= i_cfg_data[PHASE_W-1:0];
                CFG_ACK_WAIT:    r_ack_wait    <= i_cfg_data[ACK_W-1:0];
                default:         r_ack_wait    <= r_ack_wait;
            endcase
        end
    end

    always_comb begin
        logic              tick_phase;
        logic              beg;
        t_cmd              bcmd;
        logic [PIDX_W-1:0] bp;
        logic [PIDX_W-1:0] rp;
        logic [PIDX_W-1:0] bq;
        logic [1:0]        r3;
        logic [2:0]        bsel;
        logic [ACK_W-1:0]  len;
        logic [ACK_W-1:0]  tnext;
        logic [PIDX_W-1:0] pnext;
        logic              done;
        logic              rej;

        n_scl       = r_scl;
        n_sda       = r_sda;
        n_sda_en    = r_sda_en;
        n_cmd       = r_cmd;
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_shift     = r_shift;
        n_ack       = r_ack;
        n_last_read = r_last_read;
        beg         = 1'b0;
        bcmd        = r_cmd;
        bp          = r_phase;
        done        = 1'b0;
        rej         = 1'b0;
        tick_phase  = 1'b0;
        rp          = '0;
        bq          = '0;
        r3          = '0;
        bsel        = '0;
        pnext       = r_phase + 5'd1;
        tnext       = r_tick + 12'd1;

        if (r_cmd == CS_WRITE && r_phase == WR_ACK_PHASE) begin
            len = r_ack_wait;
        end else begin
            len = {{(ACK_W-PHASE_W){1'b0}}, r_phase_ticks};
        end
        if (len == '0) begin
            len = 12'd1;
        end

        case (t_kind'(i_kind))
            K_TICK: begin
                if (r_cmd != CS_IDLE) begin
                    tick_phase = 1'b1;
                end
            end
            K_START, K_STOP, K_WRITE, K_READ, K_NOACK: begin
                if (r_cmd != CS_IDLE) begin
                    rej = 1'b1;
                end else begin
                    case (t_kind'(i_kind))
                        K_START: bcmd = CS_START;
                        K_STOP:  bcmd = CS_STOP;
                        K_WRITE: bcmd = CS_WRITE;
                        K_READ:  bcmd = CS_READ;
                        default: bcmd = CS_NOACK;
                    endcase
                    n_cmd   = bcmd;
                    n_phase = '0;
                    n_tick  = '0;
                    n_shift = (t_kind'(i_kind) == K_WRITE) ? i_data : '0;
                    bp      = '0;
                    beg     = 1'b1;
                end
            end
            default: ;
        endcase

        if (tick_phase) begin
            n_tick = tnext;
            if (tnext >= len) begin
                if (r_cmd == CS_WRITE && r_phase == WR_ACK_PHASE) begin
                    n_ack = ~i_sda_in;
                end else if (r_cmd == CS_READ && r_phase != '0
                             && mod3(r_phase - 5'd1) == 2'd1) begin
                    n_shift = {r_shift[BYTE_W-2:0], i_sda_in};
                end
                n_tick  = '0;
                n_phase = pnext;
                if (pnext >= phase_total(r_cmd)) begin
                    if (r_cmd == CS_WRITE) begin
                        n_sda_en = 1'b1;
                    end
                    if (r_cmd == CS_READ) begin
                        n_last_read = n_shift;
                    end
                    n_cmd   = CS_IDLE;
                    n_phase = '0;
                    done    = 1'b1;
                end else begin
                    bp  = pnext;
                    beg = 1'b1;
                end
            end
        end

        if (beg) begin
            case (bcmd)
                CS_START: begin
                    case (bp[1:0])
                        2'd0:    begin n_sda = 1'b1; n_sda_en = 1'b1; end
                        2'd1:    n_scl = 1'b1;
                        2'd2:    begin n_sda = 1'b0; n_sda_en = 1'b1; end
                        default: n_scl = 1'b0;
                    endcase
                end
                CS_STOP: begin
                    case (bp[1:0])
                        2'd0:    begin n_sda = 1'b0; n_sda_en = 1'b1; end
                        2'd1:    n_scl = 1'b1;
                        default: begin n_sda = 1'b1; n_sda_en = 1'b1; end
                    endcase
                end
                CS_NOACK: begin
                    case (bp[1:0])
                        2'd0:    begin n_sda = 1'b1; n_sda_en = 1'b1; end
                        2'd1:    n_scl = 1'b1;
                        2'd2:    n_scl = 1'b0;
                        default: begin n_sda = 1'b0; n_sda_en = 1'b1; end
                    endcase
                end
                CS_WRITE: begin
                    if (bp < WR_BIT_END) begin
                        r3   = mod3(bp);
                        bq   = div3(bp);
                        bsel = ~bq[2:0];
                        case (r3)
                            2'd0: begin
                                n_sda    = n_shift[bsel];
                                n_sda_en = 1'b1;
                            end
                            2'd1:    n_scl = 1'b1;
                            default: n_scl = 1'b0;
                        endcase
                    end else if (bp == WR_REL_PHASE) begin
                        n_sda_en = 1'b0;
                    end else if (bp == WR_ACK_PHASE) begin
                        n_scl = 1'b1;
                    end else if (bp == WR_LOW_PHASE) begin
                        n_scl = 1'b0;
                    end
                end
                CS_READ: begin
                    if (bp == '0) begin
                        n_sda_en = 1'b0;
                    end else begin
                        rp = bp - 5'd1;
                        r3 = mod3(rp);
                        case (r3)
                            2'd1:    n_scl = 1'b1;
                            2'd2:    n_scl = 1'b0;
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end

        res.scl        = n_scl;
        res.sda_out    = n_sda;
        res.sda_drive  = n_sda_en;
        res.busy       = (n_cmd != CS_IDLE);
        res.done       = done;
        res.ack_ok     = n_ack;
        res.read_value = n_last_read;
        res.rejected   = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scl       <= 1'b1;
            r_sda       <= 1'b1;
            r_sda_en    <= 1'b1;
            r_cmd       <= CS_IDLE;
            r_phase     <= '0;
            r_tick      <= '0;
            r_shift     <= '0;
            r_ack       <= 1'b0;
            r_last_read <= '0;
        end else if (accept) begin
            r_scl       <= n_scl;
            r_sda       <= n_sda;
            r_sda_en    <= n_sda_en;
            r_cmd       <= n_cmd;
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_shift     <= n_shift;
            r_ack       <= n_ack;
            r_last_read <= n_last_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= accept;
            end
        end else if (accept) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_vld) begin
                r_out <= r_skid;
            end else if (accept) begin
                r_out <= res;
            end
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_scl        = r_out.scl;
    assign o_sda_out    = r_out.sda_out;
    assign o_sda_drive  = r_out.sda_drive;
    assign o_busy_res   = r_out.busy;
    assign o_done_res   = r_out.done;
    assign o_ack_ok     = r_out.ack_ok;
    assign o_read_value = r_out.read_value;
    assign o_rejected   = r_out.rejected;

endmodule
